### rtl/prwd_pkg.sv
// ----------------------------------------------------------------------------
// prwd_pkg
// Shared types and codes for the pixel readout word decoder: controller
// states, command and status bundles, result kinds and message types.
// ----------------------------------------------------------------------------
package prwd_pkg;

  // quotient bits produced per divide cycle, and divide cycles per hit
  localparam int DIV_BITS_PER_STEP = 8;
  localparam int DIV_STEPS         = 64 / DIV_BITS_PER_STEP;
  localparam int DIV_CNT_W         = $clog2(DIV_STEPS);

  // config register indexes
  localparam logic [1:0] CFG_TOT_DIVIDER  = 2'd0;
  localparam logic [1:0] CFG_COLUMN_COUNT = 2'd1;
  localparam logic [1:0] CFG_ROW_COUNT    = 2'd2;

  // result kinds
  localparam logic [3:0] KIND_HIT      = 4'd0;
  localparam logic [3:0] KIND_EARLY    = 4'd1;
  localparam logic [3:0] KIND_OUTSIDE  = 4'd2;
  localparam logic [3:0] KIND_STOP     = 4'd3;
  localparam logic [3:0] KIND_READOUT  = 4'd4;
  localparam logic [3:0] KIND_TS_HIGH  = 4'd5;
  localparam logic [3:0] KIND_TS_MID   = 4'd6;
  localparam logic [3:0] KIND_TS_LOW   = 4'd7;
  localparam logic [3:0] KIND_T0       = 4'd8;
  localparam logic [3:0] KIND_INFO     = 4'd9;
  localparam logic [3:0] KIND_OVERFLOW = 4'd10;
  localparam logic [3:0] KIND_LOCK     = 4'd11;
  localparam logic [3:0] KIND_LOCKLOST = 4'd12;
  localparam logic [3:0] KIND_WEIRD    = 4'd13;
  localparam logic [3:0] KIND_UNKNOWN  = 4'd14;
  localparam logic [3:0] KIND_STOPPED  = 4'd15;

  // message types (top byte of a non-hit word)
  localparam logic [7:0] MSG_READOUT = 8'h40;
  localparam logic [7:0] MSG_TS_HIGH = 8'h30;
  localparam logic [7:0] MSG_TS_MID  = 8'h20;
  localparam logic [7:0] MSG_TS_LOW  = 8'h60;
  localparam logic [7:0] MSG_T0      = 8'h70;
  localparam logic [7:0] MSG_TRIG    = 8'h10;
  localparam logic [7:0] MSG_BUSY    = 8'h02;
  localparam logic [7:0] MSG_EMPTY   = 8'h00;
  localparam logic [7:0] ST_LOCK     = 8'h08;
  localparam logic [7:0] ST_LOCKLOST = 8'h0C;
  localparam logic [7:0] ST_WEIRD    = 8'h04;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic load_word;
    logic exec;
    logic div_step;
    logic div_last;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic needs_div;
  } sts_t;

endpackage

### rtl/prwd_ctrl.sv
// ----------------------------------------------------------------------------
// prwd_ctrl
// Sequencer for the decoder: takes a word, runs the execute step, the divide
// steps for hits after exactly one T0, then hands the result to the output register.
// ----------------------------------------------------------------------------
module prwd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  prwd_pkg::sts_t sts,
  output prwd_pkg::cmd_t cmd
);
  import prwd_pkg::*;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 slot_free;

  assign slot_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cnt_nxt = '0;
        if (sts.needs_div) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_LOAD;
        end
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_word = in_valid;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cmd.div_last = (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
      end
      ST_LOAD: begin
        cmd.load_out = slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/prwd_datapath.sv
// ----------------------------------------------------------------------------
// prwd_datapath
// Word decode, timestamp assembly, hit time unwrapping, a radix-256
// divider for the ToT phase, config registers and the output register.
// ----------------------------------------------------------------------------
module prwd_datapath (
  input  logic           clk,
  input  logic           rst_n,
  input  prwd_pkg::cmd_t cmd,
  output prwd_pkg::sts_t sts,
  input  logic [31:0]    in_word,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [9:0]     cfg_data,
  output logic [3:0]     out_kind,
  output logic [5:0]     out_column,
  output logic [8:0]     out_row,
  output logic [63:0]    out_hit_time,
  output logic [5:0]     out_tot,
  output logic [63:0]    out_fpga_time,
  output logic [63:0]    out_readout_time
);
  import prwd_pkg::*;

  function automatic logic [9:0] ungray10(input logic [9:0] g);
    logic [9:0] b;
    b[9] = g[9];
    for (int i = 8; i >= 0; i--) begin
      b[i] = b[i+1] ^ g[i];
    end
    return b;
  endfunction

  function automatic logic [5:0] ungray6(input logic [5:0] g);
    logic [5:0] b;
    b[5] = g[5];
    for (int i = 4; i >= 0; i--) begin
      b[i] = b[i+1] ^ g[i];
    end
    return b;
  endfunction

  function automatic logic [3:0] status_kind(input logic [7:0] t);
    logic [3:0] k;
    if ((t & 8'hF2) != 8'h00) begin
      k = KIND_UNKNOWN;
    end else if ((t & 8'hF3) == 8'h01) begin
      k = KIND_OVERFLOW;
    end else begin
      unique case (t & 8'hFE)
        ST_LOCK:     k = KIND_LOCK;
        ST_LOCKLOST: k = KIND_LOCKLOST;
        ST_WEIRD:    k = KIND_WEIRD;
        default:     k = KIND_UNKNOWN;
      endcase
    end
    return k;
  endfunction

  // config
  logic [8:0]  tot_div_r;
  logic [6:0]  col_cnt_r;
  logic [9:0]  row_cnt_r;

  // decoder state
  logic [63:0] readout_r, readout_nxt;
  logic [63:0] fpga_r, fpga_nxt;
  logic [15:0] ts_high_r, ts_high_nxt;   // bits 63:48
  logic [39:0] ts_mid_r, ts_mid_nxt;     // bits 63:24, may carry upward
  logic [23:0] ts_low_r, ts_low_nxt;
  logic        high_fresh_r, high_fresh_nxt;
  logic        mid_fresh_r, mid_fresh_nxt;
  logic [1:0]  marks_r, marks_nxt;
  logic        halted_r, halted_nxt;

  // work registers
  logic [31:0] word_r;
  logic [5:0]  fine_r;
  logic [63:0] dvd_r, dvd_nxt;
  logic [8:0]  rem_r, rem_nxt;
  logic [5:0]  quo_r, quo_nxt;

  // pending result
  logic [3:0]  res_kind_r, res_kind_nxt;
  logic [5:0]  res_col_r, res_col_nxt;
  logic [8:0]  res_row_r, res_row_nxt;
  logic [63:0] res_ht_r, res_ht_nxt;
  logic [5:0]  res_tot_r;

  // output register
  logic [3:0]  out_kind_r;
  logic [5:0]  out_col_r;
  logic [8:0]  out_row_r;
  logic [63:0] out_ht_r;
  logic [5:0]  out_tot_r;
  logic [63:0] out_fpga_r;
  logic [63:0] out_readout_r;

  logic [7:0]  msg_type;
  logic [8:0]  div_eff;
  logic [5:0]  hit_col;
  logic [8:0]  hit_row;
  logic [10:0] coarse;
  logic signed [11:0] hit_d;
  logic signed [17:0] ro_d;
  logic [16:0] ro_a;
  logic [63:0] hit_time;
  logic [39:0] mid_word;
  logic        hit_ok;

  assign msg_type = word_r[31:24];
  assign div_eff  = (tot_div_r == 9'd0) ? 9'd1 : tot_div_r;
  assign hit_col  = word_r[30:25];
  assign hit_row  = word_r[24:16];
  assign coarse   = {ungray10(word_r[15:6]), 1'b0};
  assign hit_ok   = !halted_r && word_r[31] && (marks_r == 2'd1);
  assign sts.needs_div = hit_ok;

  // coarse stamp unwrapped against the low 11 bits of readout start
  // (a step of 0x800 is the same either way in 12 bits)
  always_comb begin
    hit_d = $signed({1'b0, coarse}) - $signed({1'b0, readout_r[10:0]});
    if (hit_d > 12'sd0) begin
      if (hit_d > 12'sd511) begin
        hit_d = hit_d - 12'sh800;
      end
    end else if (hit_d < -12'sd1537) begin
      hit_d = hit_d + 12'sh800;
    end
  end

  assign hit_time = readout_r + {{52{hit_d[11]}}, hit_d};

  // 17-bit unwrap of the readout stamp against the fpga time
  assign ro_a = {word_r[23:8], 1'b0};
  always_comb begin
    ro_d = $signed({1'b0, ro_a}) - $signed({1'b0, fpga_r[16:0]});
    if (ro_d > 18'sd0) begin
      if (ro_d > 18'sd65536) begin
        ro_d = ro_d - 18'sh20000;
      end
    end else if (ro_d < -18'sd4096) begin
      ro_d = ro_d + 18'sh20000;
    end
  end

  assign mid_word = {16'd0, word_r[23:0]};

  // execute step
  always_comb begin
    readout_nxt    = readout_r;
    fpga_nxt       = fpga_r;
    ts_high_nxt    = ts_high_r;
    ts_mid_nxt     = ts_mid_r;
    ts_low_nxt     = ts_low_r;
    high_fresh_nxt = high_fresh_r;
    mid_fresh_nxt  = mid_fresh_r;
    marks_nxt      = marks_r;
    halted_nxt     = halted_r;
    res_kind_nxt   = KIND_UNKNOWN;
    res_col_nxt    = '0;
    res_row_nxt    = '0;
    res_ht_nxt     = '0;
    if (halted_r) begin
      res_kind_nxt = KIND_STOPPED;
    end else if (word_r[31]) begin
      if (marks_r == 2'd0) begin
        res_kind_nxt = KIND_EARLY;
      end else if (marks_r != 2'd1) begin
        halted_nxt   = 1'b1;
        res_kind_nxt = KIND_STOP;
      end else begin
        res_col_nxt = hit_col;
        res_row_nxt = hit_row;
        res_ht_nxt  = hit_time;
        if ({1'b0, hit_col} >= col_cnt_r || {1'b0, hit_row} >= row_cnt_r) begin
          res_kind_nxt = KIND_OUTSIDE;
        end else begin
          res_kind_nxt = KIND_HIT;
        end
      end
    end else begin
      unique case (msg_type) inside
        MSG_READOUT: begin
          readout_nxt  = fpga_r + {{46{ro_d[17]}}, ro_d};
          res_kind_nxt = KIND_READOUT;
        end
        MSG_TS_HIGH: begin
          ts_high_nxt    = word_r[15:0];
          high_fresh_nxt = 1'b1;
          res_kind_nxt   = KIND_TS_HIGH;
        end
        MSG_TS_MID: begin
          // high part missed: the mid part wrapped, carry into it
          if (!high_fresh_r && mid_word < ts_mid_r) begin
            ts_high_nxt = ts_high_r + 16'd1;
          end
          high_fresh_nxt = 1'b0;
          mid_fresh_nxt  = 1'b1;
          ts_mid_nxt     = mid_word;
          res_kind_nxt   = KIND_TS_MID;
        end
        MSG_TS_LOW: begin
          if (!mid_fresh_r && word_r[23:0] < ts_low_r) begin
            ts_mid_nxt = ts_mid_r + 40'd1;
          end
          mid_fresh_nxt = 1'b0;
          ts_low_nxt    = word_r[23:0];
          fpga_nxt      = {ts_high_nxt, 48'd0} | {ts_mid_nxt, 24'd0}
                          | {40'd0, word_r[23:0]};
          res_kind_nxt  = KIND_TS_LOW;
        end
        MSG_T0: begin
          high_fresh_nxt = 1'b0;
          mid_fresh_nxt  = 1'b0;
          fpga_nxt       = '0;
          ts_high_nxt    = '0;
          ts_mid_nxt     = '0;
          ts_low_nxt     = '0;
          if (marks_r != 2'd2) begin
            marks_nxt = marks_r + 2'd1;
          end
          res_kind_nxt = KIND_T0;
        end
        MSG_TRIG, MSG_BUSY, MSG_EMPTY: begin
          res_kind_nxt = KIND_INFO;
        end
        default: begin
          res_kind_nxt = status_kind(msg_type);
        end
      endcase
    end
  end

  // restoring divide, several quotient bits per cycle; only the low six
  // quotient bits are kept, they equal the phase within 64 fine periods
  always_comb begin : div_step_blk
    logic [9:0]  rem;
    logic [63:0] dvd;
    logic [5:0]  quo;
    rem = {1'b0, rem_r};
    dvd = dvd_r;
    quo = quo_r;
    for (int i = 0; i < DIV_BITS_PER_STEP; i++) begin
      rem = {rem[8:0], dvd[63]};
      dvd = {dvd[62:0], 1'b0};
      if (rem >= {1'b0, div_eff}) begin
        rem = rem - {1'b0, div_eff};
        quo = {quo[4:0], 1'b1};
      end else begin
        quo = {quo[4:0], 1'b0};
      end
    end
    rem_nxt = rem[8:0];
    dvd_nxt = dvd;
    quo_nxt = quo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_div_r    <= 9'd1;
      col_cnt_r    <= 7'd64;
      row_cnt_r    <= 10'd512;
      readout_r    <= '0;
      fpga_r       <= '0;
      ts_high_r    <= '0;
      ts_mid_r     <= '0;
      ts_low_r     <= '0;
      high_fresh_r <= 1'b0;
      mid_fresh_r  <= 1'b0;
      marks_r      <= '0;
      halted_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TOT_DIVIDER:  tot_div_r <= cfg_data[8:0];
          CFG_COLUMN_COUNT: col_cnt_r <= cfg_data[6:0];
          CFG_ROW_COUNT:    row_cnt_r <= cfg_data;
          default:          tot_div_r <= tot_div_r;
        endcase
      end
      if (cmd.exec) begin
        readout_r    <= readout_nxt;
        fpga_r       <= fpga_nxt;
        ts_high_r    <= ts_high_nxt;
        ts_mid_r     <= ts_mid_nxt;
        ts_low_r     <= ts_low_nxt;
        high_fresh_r <= high_fresh_nxt;
        mid_fresh_r  <= mid_fresh_nxt;
        marks_r      <= marks_nxt;
        halted_r     <= halted_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_word) begin
      word_r <= in_word;
    end
    if (cmd.exec) begin
      res_kind_r <= res_kind_nxt;
      res_col_r  <= res_col_nxt;
      res_row_r  <= res_row_nxt;
      res_ht_r   <= res_ht_nxt;
      res_tot_r  <= '0;
      fine_r     <= ungray6(word_r[5:0]);
      dvd_r      <= hit_time;
      rem_r      <= '0;
      quo_r      <= '0;
    end
    if (cmd.div_step) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
    if (cmd.div_last) begin
      res_tot_r <= fine_r - quo_nxt;
    end
    if (cmd.load_out) begin
      out_kind_r    <= res_kind_r;
      out_col_r     <= res_col_r;
      out_row_r     <= res_row_r;
      out_ht_r      <= res_ht_r;
      out_tot_r     <= res_tot_r;
      out_fpga_r    <= fpga_r;
      out_readout_r <= readout_r;
    end
  end

  assign out_kind         = out_kind_r;
  assign out_column       = out_col_r;
  assign out_row          = out_row_r;
  assign out_hit_time     = out_ht_r;
  assign out_tot          = out_tot_r;
  assign out_fpga_time    = out_fpga_r;
  assign out_readout_time = out_readout_r;

endmodule

### rtl/pixel_readout_word_decoder.sv
// ----------------------------------------------------------------------------
// pixel_readout_word_decoder
// Sequence: a message word goes from accept through execute and result load;
//   a hit word (after exactly one T0) runs the divide steps between the two.
// Flow: a new word is accepted only after the previous result is loaded; the
//   ToT divider retires 8 quotient bits per cycle.
// Reset: synchronous, active low; clears all timestamp state and loads the
//   config defaults (divider 1, 64 columns, 512 rows). Config is always ready.
// ----------------------------------------------------------------------------
module pixel_readout_word_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_kind,
  output logic [5:0]  out_column,
  output logic [8:0]  out_row,
  output logic [63:0] out_hit_time,
  output logic [5:0]  out_tot,
  output logic [63:0] out_fpga_time,
  output logic [63:0] out_readout_time,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);
  import prwd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  prwd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  prwd_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_word          (in_word),
    .cfg_we           (cfg_valid & cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_kind         (out_kind),
    .out_column       (out_column),
    .out_row          (out_row),
    .out_hit_time     (out_hit_time),
    .out_tot          (out_tot),
    .out_fpga_time    (out_fpga_time),
    .out_readout_time (out_readout_time)
  );

endmodule
